>>> rtl/eqs_pkg.sv
// ============================================================================
// eqs_pkg: shared definitions for the equirectangular-to-sphere pipeline
// Widths, register codes, sine coefficients and small arithmetic helpers.
// ============================================================================
package eqs_pkg;

   // Field and register widths.
   localparam int COORD_FRAC_BITS = 4;
   localparam int MAX_CANVAS      = 8192;
   localparam int CANVAS_W        = 14;
   localparam int COORD_W         = 17;
   localparam int DIR_W           = 16;
   localparam int PHASE_W         = 32;

   // The elevation divisor is the height shifted by one more fractional bit.
   localparam int DEN_W      = CANVAS_W + COORD_FRAC_BITS + 1;
   // Dividend is {pad, coordinate, rounding half}, consumed two bits a stage.
   localparam int DVD_RAW_W  = COORD_W + PHASE_W;
   localparam int DVD_W      = DVD_RAW_W + (DVD_RAW_W % 2);
   localparam int DIV_STAGES = DVD_W / 2;

   // Polynomial datapath.
   localparam int T_W        = 31;
   localparam int ACC_W      = 32;
   localparam int PROD_W     = ACC_W + T_W;
   localparam int POLY_STEPS = 7;
   localparam int LANES      = 4;
   localparam logic [T_W-1:0] Q30_ONE = T_W'(1) << 30;

   // Configuration register indexes.
   localparam int CSR_IDX_W = 2;
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_CANVAS_WIDTH  = 2'd0,
      CSR_CANVAS_HEIGHT = 2'd1
   } csr_index_type;

   localparam logic [CANVAS_W-1:0] WIDTH_RESET  = CANVAS_W'(3840);
   localparam logic [CANVAS_W-1:0] HEIGHT_RESET = CANVAS_W'(1920);

   // One two-bit step of restoring long division.
   typedef struct packed {
      logic [DEN_W-1:0] rem;
      logic [1:0]       q;
   } div_step_type;

   // Quarter-wave sine coefficients in Q30, lowest order first.
   function automatic logic signed [ACC_W-1:0] sine_coef(input int idx);
      logic signed [ACC_W-1:0] c;
      case (idx)
         0:       c = 32'sd1686629713;
         1:       c = -32'sd693598668;
         2:       c = 32'sd85569306;
         3:       c = -32'sd5026995;
         4:       c = 32'sd172272;
         default: c = -32'sd3864;
      endcase
      return c;
   endfunction

   // A canvas size of zero reads as one; sizes above the maximum are capped.
   function automatic logic [CANVAS_W-1:0] canvas_clamp(input logic [CANVAS_W-1:0] v);
      logic [CANVAS_W-1:0] r;
      r = v;
      if (v == '0) begin
         r = CANVAS_W'(1);
      end else if (v > CANVAS_W'(MAX_CANVAS)) begin
         r = CANVAS_W'(MAX_CANVAS);
      end
      return r;
   endfunction

   function automatic div_step_type div_step2(input logic [DEN_W-1:0] rem,
                                              input logic [1:0]       bits,
                                              input logic [DEN_W-1:0] den);
      div_step_type     res;
      logic [DEN_W-1:0] r;
      logic [DEN_W-1:0] rs;
      r = rem;
      for (int i = 1; i >= 0; i--) begin
         rs = {r[DEN_W-2:0], bits[i]};
         if (rs >= den) begin
            r = rs - den;
            res.q[i] = 1'b1;
         end else begin
            r = rs;
            res.q[i] = 1'b0;
         end
      end
      res.rem = r;
      return res;
   endfunction

   function automatic logic [ACC_W-1:0] mag32(input logic signed [ACC_W-1:0] a);
      return a[ACC_W-1] ? ACC_W'(-a) : ACC_W'(a);
   endfunction

endpackage

>>> rtl/equirect_pixel_to_sphere_top.sv
// ============================================================================
// equirect_pixel_to_sphere_top: panorama pixel to unit sphere direction
// Divides the pixel position into turn phases, evaluates sine and cosine
// with a pipelined polynomial and forms the Q1.15 direction vector.
// ============================================================================
//   channel | direction | handshake        | payload
//   req     | in        | valid / stall    | screen_x, screen_y (U13.4)
//   rsp     | out       | valid / stall    | dir_x, dir_y, dir_z (S1.15)
//   csr     | in        | write enable     | index, wdata (canvas size)
//
// One item enters per cycle while the skid is empty; each item passes
// 25 divider stages (two quotient bits each), one phase stage, 14 polynomial
// stages (seven multiply/round pairs), a quadrant fold stage, a product stage
// and the output register. Reset is synchronous and restores the canvas size
// to 3840 by 1920. A stalled result holds in the output register; one more
// item parks in a skid register, after which the pipe freezes as a whole.
// ============================================================================
module equirect_pixel_to_sphere_top
   import eqs_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic [COORD_W-1:0]       req_screen_x,
   input  logic [COORD_W-1:0]       req_screen_y,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic signed [DIR_W-1:0]  rsp_dir_x,
   output logic signed [DIR_W-1:0]  rsp_dir_y,
   output logic signed [DIR_W-1:0]  rsp_dir_z,
   input  logic                     csr_write,
   input  csr_index_type            csr_index,
   input  logic [CANVAS_W-1:0]      csr_wdata
);

   localparam int QS_STG   = DIV_STAGES;
   localparam int POLY_STG = QS_STG + 1;
   localparam int CB_STG   = POLY_STG + 2 * POLY_STEPS;
   localparam int PD_STG   = CB_STG + 1;
   localparam int NSTG     = PD_STG + 1;
   localparam int RND_W    = 64 - 45;

   // Canvas registers, stored already clamped.
   logic [CANVAS_W-1:0] width_ff;
   logic [CANVAS_W-1:0] height_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= canvas_clamp(WIDTH_RESET);
         height_ff <= canvas_clamp(HEIGHT_RESET);
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_CANVAS_WIDTH:  width_ff  <= canvas_clamp(csr_wdata);
            CSR_CANVAS_HEIGHT: height_ff <= canvas_clamp(csr_wdata);
            default: ;
         endcase
      end
   end

   // Divisors and rounding halves for azimuth and elevation.
   logic [DEN_W-1:0] den [2];
   logic [DEN_W-1:0] half [2];

   assign den[0]  = DEN_W'({width_ff, COORD_FRAC_BITS'(0)});
   assign den[1]  = DEN_W'({height_ff, (COORD_FRAC_BITS + 1)'(0)});
   assign half[0] = den[0] >> 1;
   assign half[1] = den[1] >> 1;

   // Pipeline control: every stage moves together unless the skid is full.
   logic            en;
   logic [NSTG-1:0] valid_ff;
   logic            skid_valid_ff;

   assign en        = !skid_valid_ff;
   assign req_stall = !en;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (en) begin
         valid_ff <= {valid_ff[NSTG-2:0], req_valid};
      end
   end

   // ---------------------------------------------------------------------
   // Long division, two quotient bits per stage, one lane per axis.
   // ---------------------------------------------------------------------
   logic [DVD_W-1:0]   dv_dvd_ff [DIV_STAGES][2];
   logic [DEN_W-1:0]   dv_rem_ff [DIV_STAGES][2];
   logic [PHASE_W-1:0] dv_quo_ff [DIV_STAGES][2];

   for (genvar k = 0; k < DIV_STAGES; k++) begin : g_div
      logic [DVD_W-1:0]   src_dvd [2];
      logic [DEN_W-1:0]   src_rem [2];
      logic [PHASE_W-1:0] src_quo [2];
      div_step_type       st [2];

      if (k == 0) begin : g_first
         assign src_dvd[0] = DVD_W'({req_screen_x, PHASE_W'(half[0])});
         assign src_dvd[1] = DVD_W'({req_screen_y, PHASE_W'(half[1])});
         assign src_rem[0] = '0;
         assign src_rem[1] = '0;
         assign src_quo[0] = '0;
         assign src_quo[1] = '0;
      end else begin : g_next
         assign src_dvd = dv_dvd_ff[k-1];
         assign src_rem = dv_rem_ff[k-1];
         assign src_quo = dv_quo_ff[k-1];
      end

      always_comb begin
         for (int l = 0; l < 2; l++) begin
            st[l] = div_step2(src_rem[l], src_dvd[l][DVD_W-1 -: 2], den[l]);
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            for (int l = 0; l < 2; l++) begin
               dv_dvd_ff[k][l] <= src_dvd[l] << 2;
               dv_rem_ff[k][l] <= st[l].rem;
               dv_quo_ff[k][l] <= {src_quo[l][PHASE_W-3:0], st[l].q};
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // Phase stage: quadrant and quarter-wave arguments for sine and cosine.
   // Lanes: 0 azimuth sine, 1 azimuth cosine, 2 elevation sine, 3 cosine.
   // ---------------------------------------------------------------------
   logic [T_W-1:0]     qs_t_ff [LANES];
   logic [3:0]         qs_quad_ff;
   logic [PHASE_W-1:0] ph_a;
   logic [PHASE_W-1:0] ph_e;

   assign ph_a = dv_quo_ff[DIV_STAGES-1][0];
   assign ph_e = dv_quo_ff[DIV_STAGES-1][1] - (PHASE_W'(1) << 30);

   always_ff @(posedge clock) begin
      if (en) begin
         qs_quad_ff <= {ph_a[PHASE_W-1 -: 2], ph_e[PHASE_W-1 -: 2]};
         qs_t_ff[0] <= {1'b0, ph_a[29:0]};
         qs_t_ff[1] <= Q30_ONE - {1'b0, ph_a[29:0]};
         qs_t_ff[2] <= {1'b0, ph_e[29:0]};
         qs_t_ff[3] <= Q30_ONE - {1'b0, ph_e[29:0]};
      end
   end

   // ---------------------------------------------------------------------
   // Polynomial: each step is a multiply stage and a round/accumulate stage.
   // Step 0 squares t, steps 1..5 run Horner on t^2, step 6 multiplies by t.
   // ---------------------------------------------------------------------
   logic [T_W-1:0]          pm_t_ff    [POLY_STEPS][LANES];
   logic [T_W-1:0]          pm_t2_ff   [POLY_STEPS][LANES];
   logic [PROD_W-1:0]       pm_prod_ff [POLY_STEPS][LANES];
   logic                    pm_neg_ff  [POLY_STEPS][LANES];
   logic [3:0]              pm_quad_ff [POLY_STEPS];
   logic [T_W-1:0]          pr_t_ff    [POLY_STEPS][LANES];
   logic [T_W-1:0]          pr_t2_ff   [POLY_STEPS][LANES];
   logic signed [ACC_W-1:0] pr_acc_ff  [POLY_STEPS][LANES];
   logic [3:0]              pr_quad_ff [POLY_STEPS];

   for (genvar j = 0; j < POLY_STEPS; j++) begin : g_poly
      logic [T_W-1:0]          src_t    [LANES];
      logic [T_W-1:0]          src_t2   [LANES];
      logic signed [ACC_W-1:0] src_acc  [LANES];
      logic [3:0]              src_quad;
      logic [ACC_W-1:0]        a_mag    [LANES];
      logic [T_W-1:0]          b_op     [LANES];
      logic                    a_neg    [LANES];
      logic [PROD_W:0]         rsum     [LANES];
      logic [ACC_W:0]          m        [LANES];
      logic signed [ACC_W+1:0] sval     [LANES];

      if (j == 0) begin : g_first
         assign src_t    = qs_t_ff;
         assign src_quad = qs_quad_ff;
         for (genvar l = 0; l < LANES; l++) begin : g_lane
            assign src_t2[l]  = '0;
            assign src_acc[l] = '0;
         end
      end else begin : g_next
         assign src_t    = pr_t_ff[j-1];
         assign src_t2   = pr_t2_ff[j-1];
         assign src_acc  = pr_acc_ff[j-1];
         assign src_quad = pr_quad_ff[j-1];
      end

      // Operand selection for this step's multiply.
      always_comb begin
         for (int l = 0; l < LANES; l++) begin
            if (j == 0) begin
               a_mag[l] = ACC_W'(src_t[l]);
               b_op[l]  = src_t[l];
               a_neg[l] = 1'b0;
            end else if (j == POLY_STEPS - 1) begin
               a_mag[l] = mag32(src_acc[l]);
               b_op[l]  = src_t[l];
               a_neg[l] = src_acc[l][ACC_W-1];
            end else begin
               a_mag[l] = mag32(src_acc[l]);
               b_op[l]  = src_t2[l];
               a_neg[l] = src_acc[l][ACC_W-1];
            end
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            pm_quad_ff[j] <= src_quad;
            for (int l = 0; l < LANES; l++) begin
               pm_t_ff[j][l]    <= src_t[l];
               pm_t2_ff[j][l]   <= src_t2[l];
               pm_prod_ff[j][l] <= PROD_W'(a_mag[l]) * PROD_W'(b_op[l]);
               pm_neg_ff[j][l]  <= a_neg[l];
            end
         end
      end

      // Round half away from zero back to Q30; steps 1..5 then add the coefficient.
      always_comb begin
         for (int l = 0; l < LANES; l++) begin
            rsum[l] = {1'b0, pm_prod_ff[j][l]} + ((PROD_W + 1)'(1) << 29);
            m[l]    = rsum[l][30 +: ACC_W+1];
            sval[l] = pm_neg_ff[j][l] ? -$signed({1'b0, m[l]}) : $signed({1'b0, m[l]});
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            pr_quad_ff[j] <= pm_quad_ff[j];
            for (int l = 0; l < LANES; l++) begin
               pr_t_ff[j][l] <= pm_t_ff[j][l];
               if (j == 0) begin
                  pr_t2_ff[j][l]  <= m[l][T_W-1:0];
                  pr_acc_ff[j][l] <= sine_coef(5);
               end else if (j == POLY_STEPS - 1) begin
                  pr_t2_ff[j][l]  <= pm_t2_ff[j][l];
                  pr_acc_ff[j][l] <= sval[l][ACC_W-1:0];
               end else begin
                  pr_t2_ff[j][l]  <= pm_t2_ff[j][l];
                  pr_acc_ff[j][l] <= sine_coef(5 - j) + sval[l][ACC_W-1:0];
               end
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // Quadrant fold into full-circle cosine and sine.
   // ---------------------------------------------------------------------
   logic signed [ACC_W-1:0] cb_cos_az_ff;
   logic signed [ACC_W-1:0] cb_sin_az_ff;
   logic signed [ACC_W-1:0] cb_cos_el_ff;
   logic signed [ACC_W-1:0] cb_sin_el_ff;
   logic signed [ACC_W-1:0] fold_c [2];
   logic signed [ACC_W-1:0] fold_s [2];

   always_comb begin
      for (int a = 0; a < 2; a++) begin
         case (pr_quad_ff[POLY_STEPS-1][2*(1-a) +: 2])
            2'd0: begin
               fold_c[a] = pr_acc_ff[POLY_STEPS-1][2*a+1];
               fold_s[a] = pr_acc_ff[POLY_STEPS-1][2*a];
            end
            2'd1: begin
               fold_c[a] = -pr_acc_ff[POLY_STEPS-1][2*a];
               fold_s[a] = pr_acc_ff[POLY_STEPS-1][2*a+1];
            end
            2'd2: begin
               fold_c[a] = -pr_acc_ff[POLY_STEPS-1][2*a+1];
               fold_s[a] = -pr_acc_ff[POLY_STEPS-1][2*a];
            end
            default: begin
               fold_c[a] = pr_acc_ff[POLY_STEPS-1][2*a];
               fold_s[a] = -pr_acc_ff[POLY_STEPS-1][2*a+1];
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         cb_cos_az_ff <= fold_c[0];
         cb_sin_az_ff <= fold_s[0];
         cb_cos_el_ff <= fold_c[1];
         cb_sin_el_ff <= fold_s[1];
      end
   end

   // ---------------------------------------------------------------------
   // Products of elevation cosine with azimuth sine and cosine, in Q60.
   // ---------------------------------------------------------------------
   logic [2*ACC_W-1:0]      pd_px_ff;
   logic [2*ACC_W-1:0]      pd_pz_ff;
   logic                    pd_nx_ff;
   logic                    pd_nz_ff;
   logic signed [ACC_W-1:0] pd_sin_el_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         pd_px_ff     <= (2*ACC_W)'(mag32(cb_cos_el_ff)) * (2*ACC_W)'(mag32(cb_sin_az_ff));
         pd_pz_ff     <= (2*ACC_W)'(mag32(cb_cos_el_ff)) * (2*ACC_W)'(mag32(cb_cos_az_ff));
         pd_nx_ff     <= cb_cos_el_ff[ACC_W-1] != cb_sin_az_ff[ACC_W-1];
         pd_nz_ff     <= cb_cos_el_ff[ACC_W-1] != cb_cos_az_ff[ACC_W-1];
         pd_sin_el_ff <= cb_sin_el_ff;
      end
   end

   // Saturate a rounded magnitude to signed Q1.15.
   function automatic logic signed [DIR_W-1:0] q15_sat(input logic neg,
                                                        input logic [RND_W:0] mag);
      logic signed [DIR_W-1:0] v;
      if (neg) begin
         v = (mag > (RND_W+1)'(32768)) ? -16'sd32768 : DIR_W'(-mag);
      end else begin
         v = (mag > (RND_W+1)'(32767)) ? 16'sd32767 : DIR_W'(mag);
      end
      return v;
   endfunction

   // Round half away from zero to Q15.
   logic [2*ACC_W:0]        sum_x;
   logic [2*ACC_W:0]        sum_z;
   logic [ACC_W:0]          sum_y;
   logic signed [DIR_W-1:0] out_x;
   logic signed [DIR_W-1:0] out_y;
   logic signed [DIR_W-1:0] out_z;

   always_comb begin
      sum_x = {1'b0, pd_px_ff} + ((2*ACC_W+1)'(1) << 44);
      sum_z = {1'b0, pd_pz_ff} + ((2*ACC_W+1)'(1) << 44);
      sum_y = {1'b0, mag32(pd_sin_el_ff)} + ((ACC_W+1)'(1) << 14);
      out_x = q15_sat(pd_nx_ff, sum_x[45 +: RND_W+1]);
      out_z = q15_sat(pd_nz_ff, sum_z[45 +: RND_W+1]);
      out_y = q15_sat(pd_sin_el_ff[ACC_W-1], (RND_W+1)'(sum_y[ACC_W:15]));
   end

   // ---------------------------------------------------------------------
   // Output register with one skid entry.
   // ---------------------------------------------------------------------
   logic                    rsp_valid_ff;
   logic signed [DIR_W-1:0] rsp_x_ff;
   logic signed [DIR_W-1:0] rsp_y_ff;
   logic signed [DIR_W-1:0] rsp_z_ff;
   logic signed [DIR_W-1:0] skid_x_ff;
   logic signed [DIR_W-1:0] skid_y_ff;
   logic signed [DIR_W-1:0] skid_z_ff;
   logic                    rsp_take;

   assign rsp_take = !rsp_valid_ff || !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (skid_valid_ff) begin
         if (rsp_take) begin
            rsp_valid_ff  <= 1'b1;
            skid_valid_ff <= 1'b0;
         end
      end else if (rsp_take) begin
         rsp_valid_ff <= valid_ff[NSTG-1];
      end else if (valid_ff[NSTG-1]) begin
         skid_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (skid_valid_ff) begin
         if (rsp_take) begin
            rsp_x_ff <= skid_x_ff;
            rsp_y_ff <= skid_y_ff;
            rsp_z_ff <= skid_z_ff;
         end
      end else if (rsp_take) begin
         rsp_x_ff <= out_x;
         rsp_y_ff <= out_y;
         rsp_z_ff <= out_z;
      end else begin
         skid_x_ff <= out_x;
         skid_y_ff <= out_y;
         skid_z_ff <= out_z;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_dir_x = rsp_x_ff;
   assign rsp_dir_y = rsp_y_ff;
   assign rsp_dir_z = rsp_z_ff;

endmodule

>>> verif/testbench.sv
// ============================================================================
// Equirectangular pixel to sphere direction testbench
// Drives pixel positions through the valid/stall channel, predicts each
// Q1.15 direction vector with an independent fixed-point model and compares
// every result field by field. It covers canvas sizes at their limits,
// random backpressure on both sides and a long hold-off on the result side.
// ============================================================================
module testbench
   import eqs_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   localparam int  LATENCY       = 43;
   localparam int  SETTLE_CYCLES = LATENCY + 10;
   localparam int  IDLE_LIMIT    = 2000;
   localparam int  HOLD_CYCLES   = 400;
   localparam csr_index_type CSR_UNUSED = csr_index_type'(2'd3);

   // Quarter-wave sine coefficients in Q30, lowest order first.
   localparam longint QSIN_COEF [6] = '{1686629713, -693598668, 85569306,
                                        -5026995, 172272, -3864};

   typedef struct {
      logic signed [DIR_W-1:0] dir_x;
      logic signed [DIR_W-1:0] dir_y;
      logic signed [DIR_W-1:0] dir_z;
   } direction_type;

   logic                    clock;
   logic                    reset;
   logic                    req_valid;
   logic                    req_stall;
   logic [COORD_W-1:0]      req_screen_x;
   logic [COORD_W-1:0]      req_screen_y;
   logic                    rsp_valid;
   logic                    rsp_stall;
   logic signed [DIR_W-1:0] rsp_dir_x;
   logic signed [DIR_W-1:0] rsp_dir_y;
   logic signed [DIR_W-1:0] rsp_dir_z;
   logic                    csr_write;
   csr_index_type           csr_index;
   logic [CANVAS_W-1:0]     csr_wdata;

   direction_type           pending_dirs[$];
   int unsigned             model_width;
   int unsigned             model_height;
   int                      send_idle_pct;
   int                      recv_stall_pct;
   bit                      hold_request;
   int                      hold_left;
   int                      mismatch_count;
   int                      items_sent;
   int                      results_seen;
   int                      csr_writes;
   int                      idle_cycles;

   equirect_pixel_to_sphere_top i_dut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_screen_x (req_screen_x),
      .req_screen_y (req_screen_y),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_dir_x    (rsp_dir_x),
      .rsp_dir_y    (rsp_dir_y),
      .rsp_dir_z    (rsp_dir_z),
      .csr_write    (csr_write),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // ---------------------------------------------------------------------
   // Fixed-point direction predictor
   // ---------------------------------------------------------------------
   function automatic longint unsigned abs_of(longint a);
      return a < 0 ? longint'(0) - a : a;
   endfunction

   // Q30 product, rounded half away from zero.
   function automatic longint q30_mul(longint a, longint b);
      bit                neg;
      longint unsigned   p;
      neg = (a < 0) != (b < 0);
      p = (abs_of(a) * abs_of(b) + (64'd1 << 29)) >> 30;
      return neg ? -longint'(p) : longint'(p);
   endfunction

   function automatic longint quarter_wave_sin(longint t);
      longint t2;
      longint acc;
      t2 = q30_mul(t, t);
      acc = QSIN_COEF[5];
      for (int i = 4; i >= 0; i--) begin
         acc = QSIN_COEF[i] + q30_mul(acc, t2);
      end
      return q30_mul(acc, t);
   endfunction

   function automatic void phase_to_cos_sin(logic [31:0] ph, output longint c,
                                            output longint s);
      longint r;
      longint sv;
      longint cv;
      r = longint'(ph[29:0]);
      sv = quarter_wave_sin(r);
      cv = quarter_wave_sin((64'sd1 << 30) - r);
      case (ph[31:30])
         2'd0: begin c = cv;  s = sv;  end
         2'd1: begin c = -sv; s = cv;  end
         2'd2: begin c = -cv; s = -sv; end
         default: begin c = sv; s = -cv; end
      endcase
   endfunction

   // Round a magnitude down to Q15 and saturate with its sign.
   function automatic logic signed [DIR_W-1:0] round_to_q15(bit neg,
                                                            longint unsigned mag,
                                                            int sh);
      longint unsigned m;
      m = (mag + (64'd1 << (sh - 1))) >> sh;
      if (neg) begin
         return m > 32768 ? -16'sd32768 : DIR_W'(-longint'(m));
      end
      return m > 32767 ? 16'sd32767 : DIR_W'(m);
   endfunction

   function automatic int unsigned canvas_limit(logic [CANVAS_W-1:0] v);
      if (v == 0) begin
         return 1;
      end
      return v > MAX_CANVAS ? MAX_CANVAS : v;
   endfunction

   function automatic direction_type pixel_direction(logic [COORD_W-1:0] sx,
                                                     logic [COORD_W-1:0] sy);
      direction_type   d;
      longint unsigned den_az;
      longint unsigned den_el;
      longint unsigned num;
      logic [31:0]     ph_az;
      logic [31:0]     ph_el;
      longint          cos_el, sin_el, cos_az, sin_az;
      den_az = longint'(model_width) << COORD_FRAC_BITS;
      den_el = longint'(model_height) << (COORD_FRAC_BITS + 1);
      num = sx;
      ph_az = 32'(((num << 32) + den_az / 2) / den_az);
      num = sy;
      ph_el = 32'(((num << 32) + den_el / 2) / den_el) - 32'h4000_0000;
      phase_to_cos_sin(ph_az, cos_az, sin_az);
      phase_to_cos_sin(ph_el, cos_el, sin_el);
      d.dir_x = round_to_q15((cos_el < 0) != (sin_az < 0),
                             abs_of(cos_el) * abs_of(sin_az), 45);
      d.dir_y = round_to_q15(sin_el < 0, abs_of(sin_el), 15);
      d.dir_z = round_to_q15((cos_el < 0) != (cos_az < 0),
                             abs_of(cos_el) * abs_of(cos_az), 45);
      return d;
   endfunction

   // ---------------------------------------------------------------------
   // Item driver and register writes
   // ---------------------------------------------------------------------
   task automatic send_pixel(int unsigned sx, int unsigned sy);
      int gap;
      gap = 0;
      while ($urandom_range(99) < send_idle_pct && gap < 20) gap++;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid    <= 1'b1;
      req_screen_x <= COORD_W'(sx);
      req_screen_y <= COORD_W'(sy);
      do @(posedge clock); while (req_stall);
      pending_dirs = {pending_dirs, pixel_direction(COORD_W'(sx), COORD_W'(sy))};
      items_sent++;
   endtask

   // Stop offering items and let the pipe empty completely.
   task automatic drain_pipe();
      req_valid <= 1'b0;
      @(posedge clock);
      wait (pending_dirs.size() == 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_canvas(csr_index_type idx, int unsigned value);
      drain_pipe();
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_wdata <= CANVAS_W'(value);
      @(posedge clock);
      csr_write <= 1'b0;
      if (idx == CSR_CANVAS_WIDTH) begin
         model_width = canvas_limit(CANVAS_W'(value));
      end else if (idx == CSR_CANVAS_HEIGHT) begin
         model_height = canvas_limit(CANVAS_W'(value));
      end
      csr_writes++;
   endtask

   // Mostly positions on the canvas, some anywhere in the field range.
   task automatic send_random_pixel();
      int unsigned sx;
      int unsigned sy;
      if ($urandom_range(3) != 0) begin
         sx = $urandom_range(0, (model_width << 4) - 1);
         sy = $urandom_range(0, (model_height << 4));
      end else begin
         sx = $urandom & 32'h0001_FFFF;
         sy = $urandom & 32'h0001_FFFF;
      end
      send_pixel(sx, sy);
   endtask

   // ---------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------
   // Poles, equator, quadrant boundaries and field extremes at reset size.
   task automatic test_reset_canvas();
      send_pixel(0, 0);
      send_pixel(0, 15360);
      send_pixel(0, 30720);
      send_pixel(15360, 15360);
      send_pixel(30720, 15360);
      send_pixel(46080, 15360);
      send_pixel(61440, 15360);
      send_pixel(15360, 7680);
      send_pixel(46080, 23040);
      send_pixel(0, 40000);
      send_pixel(131071, 131071);
      send_pixel(131071, 0);
      send_pixel(1, 1);
   endtask

   // Zero, minimum, maximum and oversized canvas, and an unused index.
   task automatic test_canvas_limits();
      write_canvas(CSR_CANVAS_WIDTH, 0);
      write_canvas(CSR_CANVAS_HEIGHT, 0);
      send_pixel(4, 8);
      send_pixel(131071, 16);
      send_pixel(8, 131071);
      write_canvas(CSR_CANVAS_WIDTH, 8192);
      write_canvas(CSR_CANVAS_HEIGHT, 16383);
      send_pixel(65536, 65536);
      send_pixel(131071, 131071);
      send_pixel(32768, 0);
      write_canvas(CSR_UNUSED, 5);
      send_pixel(98304, 131071);
      write_canvas(CSR_CANVAS_WIDTH, 1);
      write_canvas(CSR_CANVAS_HEIGHT, 1);
      send_pixel(0, 0);
      send_pixel(8, 8);
      send_pixel(16, 16);
      send_pixel(4, 12);
   endtask

   task automatic test_random_traffic(int count, int send_pct, int recv_pct);
      send_idle_pct  = send_pct;
      recv_stall_pct = recv_pct;
      write_canvas(CSR_CANVAS_WIDTH, $urandom_range(1, 16383));
      write_canvas(CSR_CANVAS_HEIGHT, $urandom_range(1, 8192));
      repeat (count) send_random_pixel();
   endtask

   // Long result hold-off fills the pipe, then a pause until it is empty.
   task automatic test_backpressure();
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      write_canvas(CSR_CANVAS_WIDTH, 1024);
      write_canvas(CSR_CANVAS_HEIGHT, 512);
      hold_request = 1'b1;
      repeat (70) send_random_pixel();
      req_valid <= 1'b0;
      @(posedge clock);
      wait (pending_dirs.size() == 0);
      repeat (30) send_random_pixel();
   endtask

   // ---------------------------------------------------------------------
   // Result receiver: random stalls plus an occasional long hold-off.
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      if (hold_request) begin
         hold_request = 1'b0;
         hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < recv_stall_pct);
      end
   end

   // Compare each accepted result with the oldest prediction.
   always @(posedge clock) begin
      direction_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         results_seen++;
         if (pending_dirs.size() == 0) begin
            $error("unexpected result: dir_x %0d dir_y %0d dir_z %0d",
                   rsp_dir_x, rsp_dir_y, rsp_dir_z);
            mismatch_count++;
         end else begin
            want = pending_dirs.pop_front();
            if (rsp_dir_x !== want.dir_x) begin
               $error("dir_x: expected %0d, got %0d", want.dir_x, rsp_dir_x);
               mismatch_count++;
            end
            if (rsp_dir_y !== want.dir_y) begin
               $error("dir_y: expected %0d, got %0d", want.dir_y, rsp_dir_y);
               mismatch_count++;
            end
            if (rsp_dir_z !== want.dir_z) begin
               $error("dir_z: expected %0d, got %0d", want.dir_z, rsp_dir_z);
               mismatch_count++;
            end
         end
      end
   end

   // Watchdog on cycles in which neither channel moves an item.
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("Timeout after %0d idle cycles", idle_cycles);
         $display("Mismatches found");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // ---------------------------------------------------------------------
   // Test sequence
   // ---------------------------------------------------------------------
   initial begin
      reset          = 1'b1;
      req_valid      = 1'b0;
      req_screen_x   = '0;
      req_screen_y   = '0;
      rsp_stall      = 1'b0;
      csr_write      = 1'b0;
      csr_index      = CSR_CANVAS_WIDTH;
      csr_wdata      = '0;
      model_width    = 3840;
      model_height   = 1920;
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      hold_request   = 1'b0;
      hold_left      = 0;
      mismatch_count = 0;
      items_sent     = 0;
      results_seen   = 0;
      csr_writes     = 0;
      idle_cycles    = 0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_reset_canvas();
      test_canvas_limits();
      test_random_traffic(100, 18, 66);
      test_random_traffic(100, 18, 66);
      test_random_traffic(100, 66, 18);
      test_random_traffic(100, 66, 18);
      test_random_traffic(100, 0, 0);
      test_random_traffic(100, 0, 0);
      test_backpressure();

      req_valid <= 1'b0;
      @(posedge clock);
      wait (pending_dirs.size() == 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (pending_dirs.size() != 0) begin
         $error("%0d expected results never arrived", pending_dirs.size());
         mismatch_count++;
      end

      $display("Sent %0d pixel items and checked %0d directions", items_sent,
               results_seen);
      $display("across %0d canvas register writes, limits and stalls included",
               csr_writes);
      if (mismatch_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule

>>> files.f
rtl/eqs_pkg.sv
rtl/equirect_pixel_to_sphere_top.sv
verif/testbench.sv
